/* rtl/snrl_pkg.sv */
// Package for the spiking neuron with refractory learning.
// Holds the request and result structs, register indexes and reset values.
// No dependencies; the neuron unit and the checker in rtl import it.
package snrl_pkg;

  localparam int TYPES        = 4;
  localparam int SYNAPSES_DEF = 16;

  localparam int WEIGHT_W = 8;
  localparam int MEMB_W   = 16;
  localparam int TIME_W   = 32;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_STEPS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRE_CODE   = 2'd3;

  localparam logic [7:0]        THRESHOLD_RST   = 8'd16;
  localparam logic [7:0]        LEARN_STEPS_RST = 8'd1;
  localparam logic [TIME_W-1:0] REFRACTORY_RST  = 32'd10;
  localparam logic [1:0]        FIRE_CODE_RST   = 2'd0;

  // Request function codes.
  localparam logic FUNC_ARRIVAL = 1'b0;
  localparam logic FUNC_WRITE   = 1'b1;

  // Receptor sign for each transmitter type.
  localparam logic signed [2:0] RECEPTOR_SIGN [TYPES] = '{3'sd1, -3'sd1, 3'sd2, -3'sd2};

  typedef struct packed {
    logic                func;
    logic [1:0]          nt_type;
    logic [3:0]          synapse_id;
    logic [TIME_W-1:0]   now;
    logic [WEIGHT_W-1:0] weight_value;
  } snrl_in_t;

  typedef struct packed {
    logic       fired;
    logic [1:0] out_type;
  } snrl_out_t;

endpackage

/* rtl/snrl_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// A read and a write to the same address in one cycle return the old data.
// No dependencies.
module snrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/spiking_neuron_with_refractory_learning_unit.sv */
// Spiking neuron with refractory learning: one request per clock cycle while the input is not
// stalled. An accepted request passes through stage one and then the output register. The
// input stalls only while stage one holds a request behind a stalled result. The weight
// table sits in a RAM with a registered read; the request is looked up as it is accepted
// and updated as it leaves stage one, and a write made as the next request is accepted to
// the entry it reads is forwarded, so back-to-back requests to one synapse see each other.
// The membrane voltage and last firing time are registers updated in the same cycle.
// The weight RAM is not cleared: an arrival on a never-written entry reads garbage.
// Depends on snrl_pkg and snrl_ram.
module spiking_neuron_with_refractory_learning_unit #(
  parameter int SYNAPSES = snrl_pkg::SYNAPSES_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [snrl_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [snrl_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  snrl_pkg::snrl_in_t                   in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output snrl_pkg::snrl_out_t                  out_data_o
);

  import snrl_pkg::*;

  localparam int DEPTH = SYNAPSES * TYPES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Configuration registers.
  logic [7:0]        threshold_q;
  logic [7:0]        learn_steps_q;
  logic [TIME_W-1:0] refractory_q;
  logic [1:0]        fire_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q   <= THRESHOLD_RST;
      learn_steps_q <= LEARN_STEPS_RST;
      refractory_q  <= REFRACTORY_RST;
      fire_code_q   <= FIRE_CODE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_THRESHOLD:   threshold_q   <= cfg_wdata_i[7:0];
        CFG_LEARN_STEPS: learn_steps_q <= cfg_wdata_i[7:0];
        CFG_REFRACTORY:  refractory_q  <= cfg_wdata_i[TIME_W-1:0];
        CFG_FIRE_CODE:   fire_code_q   <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control.
  logic      s1_valid_q;
  snrl_in_t  s1_q;
  logic      s1_adv;
  logic      in_acc;
  logic      out_valid_q;
  snrl_out_t out_q;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Weight RAM.
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [WEIGHT_W-1:0] ram_wdata;
  logic [AW-1:0]       rd_idx;
  logic [WEIGHT_W-1:0] ram_rdata;

  assign rd_idx = AW'({in_data_i.synapse_id, in_data_i.nt_type});

  snrl_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (DEPTH)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_acc),
    .raddr_i (rd_idx),
    .rdata_o (ram_rdata)
  );

  // Forwarding of a write that lands at the edge the next request reads.
  logic                fwd_hit_q;
  logic [WEIGHT_W-1:0] fwd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else if (in_acc) begin
      fwd_hit_q <= ram_we && (ram_waddr == rd_idx);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fwd_data_q <= ram_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= in_data_i;
    end
  end

  // Neuron update for the request in stage one.
  logic [MEMB_W-1:0]   membrane_q;
  logic [TIME_W-1:0]   last_fire_q;
  logic [MEMB_W-1:0]   membrane_d;
  logic [TIME_W-1:0]   last_fire_d;
  logic                s1_in_range;
  logic [WEIGHT_W-1:0] w;
  logic [TIME_W-1:0]   since;
  logic                refr;
  logic [WEIGHT_W:0]   w_plus;
  logic [WEIGHT_W-1:0] nw;
  logic                learn_fire;
  logic signed [11:0]  prod;
  logic signed [18:0]  v;
  logic signed [18:0]  v_sat;
  logic                fire;

  assign s1_in_range = {28'd0, s1_q.synapse_id} < 32'(SYNAPSES);

  always_comb begin
    w           = s1_in_range ? (fwd_hit_q ? fwd_data_q : ram_rdata) : '0;
    since       = s1_q.now - last_fire_q;
    refr        = since <= refractory_q;
    w_plus      = {1'b0, w} + {1'b0, learn_steps_q};
    // Threshold minus weight below the step count means the ceiling was reached.
    learn_fire  = {1'b0, threshold_q} < w_plus;
    if (w < threshold_q) begin
      nw = learn_fire ? threshold_q : w_plus[WEIGHT_W-1:0];
    end else begin
      nw = w;
    end
    prod  = 12'(RECEPTOR_SIGN[s1_q.nt_type]) * $signed({4'd0, w});
    v     = $signed({3'b000, membrane_q}) + 19'(prod);
    v_sat = (v > 19'sd65535) ? 19'sd65535 : v;

    fire        = 1'b0;
    membrane_d  = membrane_q;
    last_fire_d = last_fire_q;
    ram_we      = 1'b0;
    ram_waddr   = AW'({s1_q.synapse_id, s1_q.nt_type});
    ram_wdata   = s1_q.weight_value;

    if (s1_q.func == FUNC_WRITE) begin
      ram_we = s1_adv && s1_in_range;
    end else if (refr) begin
      if (learn_steps_q != '0) begin
        ram_we    = s1_adv && s1_in_range;
        ram_wdata = nw;
        fire      = learn_fire && (membrane_q >= {8'd0, threshold_q});
      end
    end else begin
      fire = v_sat >= $signed({11'd0, threshold_q});
      if (!fire) begin
        membrane_d = v_sat[18] ? '0 : v_sat[MEMB_W-1:0];
      end
    end

    if (fire) begin
      membrane_d  = '0;
      last_fire_d = s1_q.now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      membrane_q  <= '0;
      last_fire_q <= '0;
    end else if (s1_adv) begin
      membrane_q  <= membrane_d;
      last_fire_q <= last_fire_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q.fired    <= fire;
      out_q.out_type <= fire ? fire_code_q : 2'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/snrl_checker.sv */
// Port-level checks for the spiking neuron with refractory learning.
// Depends on snrl_pkg; bound to the top level at the end of this file.
module snrl_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input snrl_pkg::snrl_in_t              in_data_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input snrl_pkg::snrl_out_t             out_data_o
);

  import snrl_pkg::*;

  // A result that is held back stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // A request that is held back stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled request changed");

  // The input side only stalls when a held result blocks the pipeline.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  // Every accepted request has a result on show once it has passed stage one and the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> ##2 out_valid_o)
    else $error("accepted request produced no result");

  // A result without a spike carries type zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.fired |-> out_data_o.out_type == 2'd0)
    else $error("type set on a result that did not fire");

endmodule

bind spiking_neuron_with_refractory_learning_unit snrl_checker u_snrl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

/* tb/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for spiking_neuron_with_refractory_learning_unit.
// Runs a directed table and random phases against a behavioural predictor of the neuron.
// Depends on snrl_pkg and the RTL under rtl.
module tb;
  import snrl_pkg::*;

  localparam int ENTRIES    = SYNAPSES_DEF * TYPES;
  localparam int PHASES     = 8;
  localparam int PHASE_REQS = 160;

  typedef struct packed {
    logic      typed;
    snrl_out_t want;
    snrl_in_t  req;
  } row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  snrl_in_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  snrl_out_t             out_data_o;

  spiking_neuron_with_refractory_learning_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Predictor state and shadow copies of the registers.
  logic [WEIGHT_W-1:0] weight_tbl [ENTRIES];
  bit                  written [ENTRIES];
  int                  written_q [$];
  int                  membrane_v;
  logic [TIME_W-1:0]   last_fire_t;
  logic [7:0]          thr_cfg;
  logic [7:0]          learn_cfg;
  logic [TIME_W-1:0]   refr_cfg;
  logic [1:0]          fire_cfg;

  snrl_out_t         spike_q [$];
  row_t              directed_rows [$];
  int                mismatches;
  int                fires_seen;
  int                results_seen;
  int                reqs_sent;
  int                snd_pct;
  int                rcv_pct;
  logic              hold_req;
  logic [TIME_W-1:0] cur_now;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("** spiking_neuron_with_refractory_learning_unit: FAILED **");
    $finish;
  end

  function automatic bit fire_check(int v, logic [TIME_W-1:0] t);
    if (v >= int'(thr_cfg)) begin
      membrane_v  = 0;
      last_fire_t = t;
      return 1'b1;
    end
    membrane_v = (v < 0) ? 0 : v;
    return 1'b0;
  endfunction

  function automatic snrl_out_t predict_spike(snrl_in_t r);
    snrl_out_t         res;
    int                idx;
    int                w;
    int                nw;
    int                v;
    logic [TIME_W-1:0] since;
    bit                fire;
    res  = '0;
    fire = 1'b0;
    idx  = int'(r.synapse_id) * TYPES + int'(r.nt_type);
    if (r.func == FUNC_WRITE) begin
      weight_tbl[idx] = r.weight_value;
      if (!written[idx]) begin
        written[idx] = 1'b1;
        written_q.insert(written_q.size(), idx);
      end
      return res;
    end
    w     = int'(weight_tbl[idx]);
    since = r.now - last_fire_t;
    if (since <= refr_cfg) begin
      // Inside the window the weight climbs towards the threshold instead of integrating.
      if (learn_cfg != 0) begin
        nw = w;
        if (w < int'(thr_cfg)) begin
          nw = (w + int'(learn_cfg) > int'(thr_cfg)) ? int'(thr_cfg) : w + int'(learn_cfg);
        end
        weight_tbl[idx] = nw[WEIGHT_W-1:0];
        if (int'(thr_cfg) - w < int'(learn_cfg)) begin
          fire = fire_check(membrane_v, r.now);
        end
      end
    end else begin
      v = membrane_v + int'(RECEPTOR_SIGN[r.nt_type]) * w;
      if (v > 65535) v = 65535;
      fire = fire_check(v, r.now);
    end
    if (fire) begin
      res.fired    = 1'b1;
      res.out_type = fire_cfg;
    end
    return res;
  endfunction

  // Arrivals only ever name entries that have been written, as the table powers up unknown.
  function automatic snrl_in_t make_req();
    snrl_in_t r;
    int       idx;
    int       span;
    r              = '0;
    r.weight_value = 8'($urandom_range(255));
    if (written_q.size() == 0 || $urandom_range(99) < 20) begin
      r.func       = FUNC_WRITE;
      r.nt_type    = 2'($urandom_range(3));
      r.synapse_id = 4'($urandom_range(15));
      r.now        = $urandom;
      if ($urandom_range(9) == 0) begin
        r.weight_value = 8'hFF;
      end else if ($urandom_range(9) < 4) begin
        r.weight_value = 8'($urandom_range(int'(thr_cfg)));
      end
      return r;
    end
    idx          = written_q[$urandom_range(written_q.size() - 1)];
    r.func       = FUNC_ARRIVAL;
    r.synapse_id = 4'(idx / TYPES);
    r.nt_type    = 2'(idx % TYPES);
    if ($urandom_range(99) < 4) begin
      cur_now = $urandom;
    end else begin
      span    = (refr_cfg > 1000) ? 20 : 2 * int'(refr_cfg) + 3;
      cur_now = cur_now + $urandom_range(span);
    end
    r.now = cur_now;
    return r;
  endfunction

  function automatic void add_row(logic f, logic [1:0] t, logic [3:0] s, logic [TIME_W-1:0] n,
                                  logic [7:0] wv, logic typed, logic fd, logic [1:0] ot);
    row_t row;
    row.req   = '{func: f, nt_type: t, synapse_id: s, now: n, weight_value: wv};
    row.typed = typed;
    row.want  = '{fired: fd, out_type: ot};
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  function automatic void report_fault(string what, snrl_out_t want, snrl_out_t seen);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected fired=%0b out_type=%0d, got fired=%0b out_type=%0d",
               $time, what, want.fired, want.out_type, seen.fired, seen.out_type);
    end
  endfunction

  task automatic offer(snrl_in_t r, logic typed, snrl_out_t want);
    snrl_out_t got;
    while (snd_pct != 0 && $urandom_range(99) < snd_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (in_stall_o);
    got = predict_spike(r);
    spike_q.insert(spike_q.size(), typed ? want : got);
    reqs_sent++;
  endtask

  task automatic set_regs(logic [7:0] thr, logic [7:0] steps, logic [TIME_W-1:0] refr,
                          logic [1:0] code);
    logic [CFG_IDX_W-1:0]  idxs [4];
    logic [CFG_DATA_W-1:0] vals [4];
    idxs = '{CFG_THRESHOLD, CFG_LEARN_STEPS, CFG_REFRACTORY, CFG_FIRE_CODE};
    vals = '{32'(thr), 32'(steps), refr, 32'(code)};
    for (int i = 0; i < 4; i++) begin
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idxs[i];
      cfg_wdata_i <= vals[i];
    end
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    thr_cfg   = thr;
    learn_cfg = steps;
    refr_cfg  = refr;
    fire_cfg  = code;
  endtask

  task automatic drain();
    while (spike_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Receiver side: random stalls, plus one long hold-off so the request path backs up.
  initial begin : stall_drive
    int hold_left;
    bit hold_done;
    hold_left   = 0;
    hold_done   = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (hold_req && !hold_done) begin
        hold_done   = 1'b1;
        hold_left   = 300;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= (rcv_pct != 0 && $urandom_range(99) < rcv_pct);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    snrl_out_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (spike_q.size() == 0) begin
        report_fault("result with no request outstanding", '0, out_data_o);
      end else begin
        exp_r = spike_q.pop_front();
        if (out_data_o.fired !== exp_r.fired) begin
          report_fault("fired mismatch", exp_r, out_data_o);
        end
        if (out_data_o.out_type !== exp_r.out_type) begin
          report_fault("out_type mismatch", exp_r, out_data_o);
        end
        if (exp_r.fired) fires_seen++;
      end
    end
  end

  initial begin : stimulus
    int p;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_THRESHOLD;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    hold_req     = 1'b0;
    snd_pct      = 0;
    rcv_pct      = 0;
    mismatches   = 0;
    fires_seen   = 0;
    results_seen = 0;
    reqs_sent    = 0;
    cur_now      = '0;
    membrane_v   = 0;
    last_fire_t  = '0;
    thr_cfg      = THRESHOLD_RST;
    learn_cfg    = LEARN_STEPS_RST;
    refr_cfg     = REFRACTORY_RST;
    fire_cfg     = FIRE_CODE_RST;
    foreach (weight_tbl[i]) begin
      weight_tbl[i] = '0;
      written[i]    = 1'b0;
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table at the reset settings. A typed-in result is checked as written.
    add_row(FUNC_WRITE,   2'd0, 4'd0,  32'd0,        8'd255, 1'b1, 1'b0, 2'd0);
    add_row(FUNC_WRITE,   2'd3, 4'd15, 32'hFFFFFFFF, 8'd255, 1'b1, 1'b0, 2'd0);
    add_row(FUNC_WRITE,   2'd1, 4'd5,  32'd7,        8'd8,   1'b1, 1'b0, 2'd0);
    add_row(FUNC_WRITE,   2'd2, 4'd5,  32'd9,        8'd7,   1'b1, 1'b0, 2'd0);
    add_row(FUNC_ARRIVAL, 2'd0, 4'd0,  32'd100,      8'd0,   1'b1, 1'b1, 2'd0);
    add_row(FUNC_ARRIVAL, 2'd0, 4'd0,  32'd105,      8'd255, 1'b0, 1'b0, 2'd0);
    add_row(FUNC_ARRIVAL, 2'd2, 4'd5,  32'd200,      8'd0,   1'b0, 1'b0, 2'd0);
    add_row(FUNC_ARRIVAL, 2'd1, 4'd5,  32'd201,      8'd0,   1'b0, 1'b0, 2'd0);
    add_row(FUNC_ARRIVAL, 2'd1, 4'd5,  32'd202,      8'd0,   1'b0, 1'b0, 2'd0);
    add_row(FUNC_ARRIVAL, 2'd2, 4'd5,  32'd203,      8'd0,   1'b0, 1'b0, 2'd0);
    add_row(FUNC_ARRIVAL, 2'd2, 4'd5,  32'd204,      8'd0,   1'b0, 1'b0, 2'd0);
    // Exactly at the edge of the window, then one tick past it.
    add_row(FUNC_ARRIVAL, 2'd2, 4'd5,  32'd214,      8'd0,   1'b0, 1'b0, 2'd0);
    add_row(FUNC_ARRIVAL, 2'd2, 4'd5,  32'd215,      8'd0,   1'b0, 1'b0, 2'd0);
    add_row(FUNC_ARRIVAL, 2'd3, 4'd15, 32'd300,      8'd0,   1'b1, 1'b0, 2'd0);
    // Timestamp wrap-around: the difference to the last firing is taken modulo 2^32.
    add_row(FUNC_ARRIVAL, 2'd0, 4'd0,  32'hFFFFFFFF, 8'd0,   1'b0, 1'b0, 2'd0);
    add_row(FUNC_ARRIVAL, 2'd0, 4'd0,  32'd5,        8'd0,   1'b0, 1'b0, 2'd0);
    add_row(FUNC_WRITE,   2'd3, 4'd15, 32'hFFFFFFFF, 8'd0,   1'b1, 1'b0, 2'd0);
    add_row(FUNC_ARRIVAL, 2'd3, 4'd15, 32'h40,       8'd0,   1'b0, 1'b0, 2'd0);
    foreach (directed_rows[i]) begin
      offer(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    end
    in_valid_i <= 1'b0;
    cur_now = 32'd1000;

    for (p = 0; p < PHASES; p++) begin
      drain();
      set_regs((p == 1) ? 8'd0 : (p == 2) ? 8'd255 : 8'($urandom_range(1, 48)),
               (p == 3) ? 8'd0 : (p == 4) ? 8'd255 : 8'($urandom_range(1, 6)),
               (p == 5) ? 32'd0 : (p == 6) ? 32'hFFFFFFFF : 32'($urandom_range(0, 30)),
               2'(p % 4));
      snd_pct = (p % 4 == 1) ? 58 : (p % 4 == 3) ? 37 : 0;
      rcv_pct = (p % 4 == 2) ? 58 : (p % 4 == 3) ? 37 : 0;
      if (p == 0) hold_req <= 1'b1;
      if (p == PHASES - 1) cur_now = 32'hFFFFFF00;
      repeat (PHASE_REQS) offer(make_req(), 1'b0, '0);
      in_valid_i <= 1'b0;
    end

    snd_pct = 0;
    rcv_pct = 0;
    while (spike_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Run covered %0d requests over %0d register settings and the reset defaults.",
             reqs_sent, PHASES);
    $display("%0d results checked, %0d of them spikes; %0d mismatches.",
             results_seen, fires_seen, mismatches);
    if (mismatches == 0) begin
      $display("** spiking_neuron_with_refractory_learning_unit: PASSED **");
    end else begin
      $display("** spiking_neuron_with_refractory_learning_unit: FAILED **");
    end
    $finish;
  end

endmodule
